@@ src/working_set_window_counter_assert.svh @@
// Assertion macros used by the RTL file of the working-set window counter.
`ifndef WORKING_SET_WINDOW_COUNTER_ASSERT_SVH
`define WORKING_SET_WINDOW_COUNTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define WSWC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define WSWC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/wswc_pkg.sv @@
`default_nettype none
package wswc_pkg;
   localparam int MAX_WINDOW_DEF = 64;
   localparam int ADDR_W         = 32;
   localparam int LEN_W          = 7;
   localparam int INDEX_W        = 32;
   localparam int TOTAL_W        = 48;
   localparam int DIV_STEPS      = 32;
   localparam int STEP_W         = 5;
   localparam int RSP_BITS       = INDEX_W + LEN_W + TOTAL_W;
   localparam int RSP_DATA_W     = ((RSP_BITS + 7) / 8) * 8;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_ADDR_W     = 3;

   // Register indexes on the configuration port.
   localparam logic REG_PAGE_BYTES    = 1'b0;
   localparam logic REG_WINDOW_LENGTH = 1'b1;

   localparam logic [31:0] PAGE_BYTES_RST    = 32'd4096;
   localparam logic [6:0]  WINDOW_LENGTH_RST = 7'd64;
endpackage
`default_nettype wire

@@ src/wswc_ram.sv @@
`default_nettype none
module wswc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

@@ src/working_set_window_counter.sv @@
// Each request: accept, a bit-serial divide of the address by page_bytes, a search of the
//   held pages, a tally and, on a window close, a result.
// One request at a time; the bit-serial divider, the page store search and, at a window
//   close, back-pressure on rsp_tready set the rate.
// Reset (synchronous, active high): page_bytes 4096, window_length 64, left_ff at
//   eff_length, other counters and totals zero; page store contents are left as they are.
`default_nettype none
`include "working_set_window_counter_assert.svh"
module working_set_window_counter
   import wswc_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // req_tdata: access_address[31:0]
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [ADDR_W-1:0]     req_tdata,
   // rsp_tdata: window_index[31:0], distinct_pages[38:32], running_total[86:39],
   //   zero[87]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);
   localparam int HELD_W = $clog2(MAX_WINDOW + 1);
   localparam int AW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DIVIDE = 5'b00010,
      S_SEARCH = 5'b00100,
      S_TALLY  = 5'b01000,
      S_EMIT   = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [31:0]         page_bytes_ff, page_bytes_in;
   logic [LEN_W-1:0]    window_length_ff, window_length_in;
   logic [LEN_W-1:0]    left_ff, left_in;
   logic [HELD_W-1:0]   held_ff, held_in;
   logic [HELD_W-1:0]   idx_ff, idx_in;
   logic                cmp_valid_ff, cmp_valid_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [ADDR_W-1:0]   quot_ff, quot_in;
   logic [ADDR_W-1:0]   rem_ff, rem_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [INDEX_W-1:0]  windows_ff, windows_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [ADDR_W-1:0]   divisor;
   logic [ADDR_W:0]     trial;
   logic [TOTAL_W:0]    sum_wide;
   logic [TOTAL_W-1:0]  total_next;
   logic [INDEX_W-1:0]  windows_next;
   logic [ADDR_W-1:0]   ram_rd_data;
   logic                ram_wr_en;
   logic                csr_write;
   logic                page_found;

   function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] res;
      if (len == '0) begin
         res = LEN_W'(1);
      end else if (32'(len) > MAX_WINDOW) begin
         res = LEN_W'(MAX_WINDOW);
      end else begin
         res = len;
      end
      return res;
   endfunction

   wswc_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (MAX_WINDOW)
   ) u_page_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (held_ff[AW-1:0]),
      .wr_data (quot_ff),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign divisor    = (page_bytes_ff == '0) ? ADDR_W'(1) : page_bytes_ff;
   assign trial      = {rem_ff, quot_ff[ADDR_W-1]} - {1'b0, divisor};
   assign sum_wide   = {1'b0, total_ff} + (TOTAL_W + 1)'(held_ff);
   assign total_next = sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];
   assign windows_next = (windows_ff == '1) ? windows_ff : windows_ff + INDEX_W'(1);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign page_found = cmp_valid_ff && (ram_rd_data == quot_ff);

   always_comb begin
      state_in         = state_ff;
      page_bytes_in    = page_bytes_ff;
      window_length_in = window_length_ff;
      left_in          = left_ff;
      held_in          = held_ff;
      idx_in           = idx_ff;
      cmp_valid_in     = 1'b0;
      step_in          = step_ff;
      quot_in          = quot_ff;
      rem_in           = rem_ff;
      total_in         = total_ff;
      windows_in       = windows_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_data_in      = rsp_data_ff;
      ram_wr_en        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               quot_in  = req_tdata;
               rem_in   = '0;
               step_in  = '0;
               state_in = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            // one restoring-division bit per cycle
            if (!trial[ADDR_W]) begin
               rem_in  = trial[ADDR_W-1:0];
               quot_in = {quot_ff[ADDR_W-2:0], 1'b1};
            end else begin
               rem_in  = {rem_ff[ADDR_W-2:0], quot_ff[ADDR_W-1]};
               quot_in = {quot_ff[ADDR_W-2:0], 1'b0};
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               idx_in   = '0;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            // issue one read a cycle, compare the entry read the cycle before
            if (page_found) begin
               state_in = S_TALLY;
            end else if (idx_ff < held_ff) begin
               idx_in       = idx_ff + HELD_W'(1);
               cmp_valid_in = 1'b1;
            end else if (!cmp_valid_ff) begin
               // not found: append unless the store is full
               if (held_ff < HELD_W'(MAX_WINDOW)) begin
                  ram_wr_en = 1'b1;
                  held_in   = held_ff + HELD_W'(1);
               end
               state_in = S_TALLY;
            end
         end
         S_TALLY: begin
            if (left_ff <= LEN_W'(1)) begin
               state_in = S_EMIT;
            end else begin
               left_in  = left_ff - LEN_W'(1);
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               total_in     = total_next;
               windows_in   = windows_next;
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({total_next, LEN_W'(held_ff), windows_next});
               held_in      = '0;
               left_in      = eff_length(window_length_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_write) begin
         case (csr_paddr[2])
            REG_PAGE_BYTES: begin
               page_bytes_in = csr_pwdata;
            end
            REG_WINDOW_LENGTH: begin
               window_length_in = csr_pwdata[LEN_W-1:0];
               left_in          = eff_length(csr_pwdata[LEN_W-1:0]);
            end
            default: begin
               page_bytes_in = page_bytes_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         page_bytes_ff    <= PAGE_BYTES_RST;
         window_length_ff <= WINDOW_LENGTH_RST;
         left_ff          <= eff_length(WINDOW_LENGTH_RST);
         held_ff          <= '0;
         idx_ff           <= '0;
         cmp_valid_ff     <= 1'b0;
         step_ff          <= '0;
         total_ff         <= '0;
         windows_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         page_bytes_ff    <= page_bytes_in;
         window_length_ff <= window_length_in;
         left_ff          <= left_in;
         held_ff          <= held_in;
         idx_ff           <= idx_in;
         cmp_valid_ff     <= cmp_valid_in;
         step_ff          <= step_in;
         total_ff         <= total_in;
         windows_ff       <= windows_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_WINDOW_LENGTH) ?
                       CSR_DATA_W'(window_length_ff) : page_bytes_ff;

   `WSWC_ASSERT_NEXT(a_accept_divides, clock, reset, req_tvalid && req_tready,
      state_ff == S_DIVIDE, "accepted request did not start the divider")
   `WSWC_ASSERT_SAME(a_held_bound, clock, reset, 1'b1,
      held_ff <= HELD_W'(MAX_WINDOW), "page count exceeds store depth")
   `WSWC_ASSERT_SAME(a_left_nonzero, clock, reset, 1'b1,
      left_ff != '0, "window access counter reached zero")
   `WSWC_ASSERT_NEXT(a_emit_clears, clock, reset,
      (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_tready),
      rsp_valid_ff && (held_ff == '0), "window close did not post result and clear")
endmodule
`default_nettype wire
